### design/size_class_block_pool_allocator_core_macros.svh
// Assertion helpers shared by the checker
`ifndef SIZE_CLASS_BLOCK_POOL_ALLOCATOR_CORE_MACROS_SVH
`define SIZE_CLASS_BLOCK_POOL_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define SCBPA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("scbpa assertion failed");

// next-cycle implication
`define SCBPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("scbpa assertion failed");

`endif

### design/scbpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbpa_pkg
// Types and constants of the size class block pool allocator.
// ----------------------------------------------------------------------------
package scbpa_pkg;

  localparam int NumPools  = 4;
  localparam int MaxBlocks = 256;
  localparam int IdxW      = $clog2(MaxBlocks);
  localparam int StepW     = $clog2(IdxW);
  localparam int PoolW     = $clog2(NumPools);
  localparam int AddrW     = 21;
  localparam int SizeW     = 11;
  localparam int CountW    = 9;
  localparam int ReqW      = 16;
  localparam int MinSize   = 4;
  localparam int MaxSize   = 1024;
  localparam int OffW      = $clog2(MaxBlocks * MaxSize) + 1;
  localparam int RowW      = 8;
  localparam int RowSelW   = $clog2(RowW);
  localparam int NumRows   = NumPools * MaxBlocks / RowW;
  localparam int RowAddrW  = $clog2(NumRows);
  localparam int StackAddrW = PoolW + IdxW;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = SizeW;
  localparam int CfgCountBit = 0;  // odd register index is a count
  localparam int RegionAlign = 16;
  localparam int BitsPerByte = 8;

  localparam logic [NumPools-1:0][SizeW-1:0] SizeReset = {
    SizeW'(128), SizeW'(64), SizeW'(32), SizeW'(16)
  };

  typedef enum logic {
    CmdAlloc = 1'b0,
    CmdFree  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    StOk         = 2'd0,
    StAllocFail  = 2'd1,
    StNotOwned   = 2'd2,
    StDoubleFree = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    BkIdle,
    BkPick,
    BkMul,
    BkAdd,
    BkMark,
    BkDiv,
    BkRowRd,
    BkCheck,
    BkDone
  } back_state_e;

  typedef struct packed {
    logic [NumPools-1:0][SizeW-1:0]  size;
    logic [NumPools-1:0][CountW-1:0] count;
    logic [NumPools-1:0][AddrW-1:0]  base;
    logic [NumPools-1:0][OffW-1:0]   bytes;
  } pool_tbl_t;

  typedef struct packed {
    cmd_e                cmd;
    logic [NumPools-1:0] fit;
    logic                owned;
    logic [PoolW-1:0]    pool;
    logic [OffW-1:0]     offset;
  } item_t;

  typedef struct packed {
    status_e          status;
    logic [AddrW-1:0] granted;
    logic [PoolW-1:0] pool;
    logic             all_free;
  } result_t;

endpackage

### design/scbpa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbpa_front
// Classifies a request: size fit per pool for allocate, owner and offset for free.
// ----------------------------------------------------------------------------
module scbpa_front import scbpa_pkg::*; (
  input  logic             cmd_i,
  input  logic [ReqW-1:0]  request_size_i,
  input  logic [AddrW-1:0] block_address_i,
  input  pool_tbl_t        tbl_i,
  output item_t            item_o
);

  always_comb begin
    logic [SizeW-1:0] last_size;
    logic             any_valid;
    logic             too_big;
    logic             found;
    logic [AddrW-1:0] diff;
    last_size = '0;
    any_valid = 1'b0;
    found     = 1'b0;
    diff      = '0;
    item_o    = '0;
    item_o.cmd = cmd_e'(cmd_i);
    // valid pools are contiguous, so the last nonzero count is the last pool
    for (int p = 0; p < NumPools; p++) begin
      if (tbl_i.count[p] != '0) begin
        any_valid = 1'b1;
        last_size = tbl_i.size[p];
      end
    end
    too_big = !any_valid ||
              (request_size_i > {{(ReqW-SizeW){1'b0}}, last_size});
    for (int p = 0; p < NumPools; p++) begin
      item_o.fit[p] = !too_big && (tbl_i.count[p] != '0) &&
                      (request_size_i <= {{(ReqW-SizeW){1'b0}}, tbl_i.size[p]});
    end
    for (int p = 0; p < NumPools; p++) begin
      diff = block_address_i - tbl_i.base[p];
      if (!found && (block_address_i >= tbl_i.base[p]) &&
          (diff < {{(AddrW-OffW){1'b0}}, tbl_i.bytes[p]})) begin
        found         = 1'b1;
        item_o.owned  = 1'b1;
        item_o.pool   = PoolW'(p);
        item_o.offset = diff[OffW-1:0];
      end
    end
  end

endmodule

### design/scbpa_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbpa_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module scbpa_queue import scbpa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t item_o
);

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wr_q <= ~wr_q;
      if (pop_i && !empty_o) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i && !full_o} - {1'b0, pop_i && !empty_o};
    end
  end

endmodule

### design/scbpa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbpa_back
// Pool table build, free stacks, block bitmap, request execution, result queue.
// ----------------------------------------------------------------------------
module scbpa_back import scbpa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output pool_tbl_t           tbl_o,
  output logic                building_o,
  input  logic                item_valid_i,
  input  item_t               item_i,
  output logic                item_pop_o,
  output result_t             res_o,
  output logic                empty,
  input  logic                pop
);

  // configuration and table
  logic [NumPools-1:0][SizeW-1:0]  size_q;
  logic [NumPools-1:0][CountW-1:0] count_q;
  pool_tbl_t                       tbl_q;
  logic                            build_q;
  logic [PoolW-1:0]                bld_p_q;
  logic [AddrW-1:0]                off_q;
  logic                            ended_q;

  // pool state
  logic [NumPools-1:0][CountW-1:0] fc_q;
  logic [NumPools-1:0][CountW-1:0] low_q;
  logic [NumRows-1:0]              row_vld_q;

  // execution
  back_state_e      state_q, state_d;
  item_t            it_q;
  logic [PoolW-1:0] pool_q;
  logic [IdxW-1:0]  idx_q;
  logic [IdxW-1:0]  pos_q;
  logic             init_q;
  logic [OffW-1:0]  rem_q;
  logic [StepW-1:0] step_q;
  logic [OffW-1:0]  prod_q;
  logic [AddrW-1:0] granted_q;
  status_e          status_q;

  // memories
  logic [IdxW-1:0] stack_mem [NumPools*MaxBlocks];
  logic [RowW-1:0] bm_mem [NumRows];
  logic [IdxW-1:0] stack_rd_q;
  logic [RowW-1:0] row_rd_q;
  logic            row_vs_q;

  // result queue
  result_t    rq_mem_q [2];
  logic       rq_wr_q, rq_rd_q;
  logic [1:0] rq_cnt_q;
  logic       rq_full;

  // build step
  logic [SizeW-1:0]  b_sz;
  logic [CountW-1:0] b_cnt, b_ecnt;
  logic              b_end;
  logic [OffW-1:0]   b_bytes;
  logic [AddrW-1:0]  b_region;

  always_comb begin
    logic [SizeW-1:0]  s;
    logic [CountW-1:0] c;
    logic [AddrW-1:0]  tmp;
    s = size_q[bld_p_q];
    c = count_q[bld_p_q];
    if (s < SizeW'(MinSize))      b_sz = SizeW'(MinSize);
    else if (s > SizeW'(MaxSize)) b_sz = SizeW'(MaxSize);
    else                          b_sz = s;
    b_cnt    = (c > CountW'(MaxBlocks)) ? CountW'(MaxBlocks) : c;
    b_end    = ended_q || (b_cnt == '0);
    b_ecnt   = b_end ? '0 : b_cnt;
    b_bytes  = OffW'(b_ecnt * b_sz);
    tmp      = AddrW'(b_bytes) + AddrW'((b_ecnt + CountW'(BitsPerByte - 1)) >> 3)
             + AddrW'(RegionAlign - 1);
    b_region = tmp & ~AddrW'(RegionAlign - 1);
  end

  // first pool that fits and has a free block
  logic             pick_ok;
  logic [PoolW-1:0] pick_p;
  logic [IdxW-1:0]  pick_pos;

  always_comb begin
    pick_ok = 1'b0;
    pick_p  = '0;
    for (int p = NumPools - 1; p >= 0; p--) begin
      if (it_q.fit[p] && (fc_q[p] != '0)) begin
        pick_ok = 1'b1;
        pick_p  = PoolW'(p);
      end
    end
    pick_pos = IdxW'(fc_q[pick_p] - CountW'(1));
  end

  logic [SizeW-1:0]      cur_size;
  logic [OffW-1:0]       trial;
  logic [IdxW-1:0]       sel_idx;
  logic [RowAddrW-1:0]   row_addr;
  logic [RowW-1:0]       row_cur;
  logic                  row_bit;
  logic                  free_ok;
  logic [StackAddrW-1:0] stack_raddr, stack_waddr;
  logic                  all_free;
  logic                  enq;

  assign cur_size    = tbl_q.size[pool_q];
  assign trial       = OffW'(cur_size) << step_q;
  assign sel_idx     = init_q ? pos_q : stack_rd_q;
  assign row_addr    = {pool_q, idx_q[IdxW-1:RowSelW]};
  assign row_cur     = row_vs_q ? row_rd_q : '0;
  assign row_bit     = row_cur[idx_q[RowSelW-1:0]];
  assign free_ok     = row_bit && (fc_q[pool_q] < CountW'(MaxBlocks));
  assign stack_raddr = {pick_p, pick_pos};
  assign stack_waddr = {pool_q, fc_q[pool_q][IdxW-1:0]};

  always_comb begin
    all_free = 1'b1;
    for (int p = 0; p < NumPools; p++) begin
      if (fc_q[p] != tbl_q.count[p]) all_free = 1'b0;
    end
  end

  // next state and strobes
  always_comb begin
    state_d    = state_q;
    item_pop_o = 1'b0;
    enq        = 1'b0;
    unique case (state_q)
      BkIdle: begin
        if (!build_q && item_valid_i) begin
          item_pop_o = 1'b1;
          if (item_i.cmd == CmdAlloc) state_d = BkPick;
          else if (item_i.owned)      state_d = BkDiv;
          else                        state_d = BkDone;
        end
      end
      BkPick:  state_d = pick_ok ? BkMul : BkDone;
      BkMul:   state_d = BkAdd;
      BkAdd:   state_d = BkMark;
      BkMark:  state_d = BkDone;
      BkDiv:   if (step_q == '0) state_d = BkRowRd;
      BkRowRd: state_d = BkCheck;
      BkCheck: state_d = BkDone;
      BkDone: begin
        if (!rq_full) begin
          enq     = 1'b1;
          state_d = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= BkIdle;
    else         state_q <= state_d;
  end

  // datapath and pool state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q    <= SizeReset;
      count_q   <= '0;
      tbl_q     <= '0;
      build_q   <= 1'b1;
      bld_p_q   <= '0;
      off_q     <= '0;
      ended_q   <= 1'b0;
      fc_q      <= '0;
      low_q     <= '0;
      row_vld_q <= '0;
      it_q      <= '0;
      pool_q    <= '0;
      idx_q     <= '0;
      pos_q     <= '0;
      init_q    <= 1'b0;
      rem_q     <= '0;
      step_q    <= '0;
      prod_q    <= '0;
      granted_q <= '0;
      status_q  <= StOk;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i[CfgCountBit]) count_q[cfg_idx_i[CfgIdxW-1:1]] <= cfg_wdata_i[CountW-1:0];
        else                        size_q[cfg_idx_i[CfgIdxW-1:1]]  <= cfg_wdata_i;
        // restart the table build and drop all bitmap rows
        build_q   <= 1'b1;
        bld_p_q   <= '0;
        off_q     <= '0;
        ended_q   <= 1'b0;
        row_vld_q <= '0;
      end else if (build_q) begin
        tbl_q.size[bld_p_q]  <= b_sz;
        tbl_q.count[bld_p_q] <= b_ecnt;
        tbl_q.base[bld_p_q]  <= off_q;
        tbl_q.bytes[bld_p_q] <= b_bytes;
        fc_q[bld_p_q]        <= b_ecnt;
        low_q[bld_p_q]       <= b_ecnt;
        off_q   <= off_q + (b_end ? '0 : b_region);
        ended_q <= b_end;
        if (bld_p_q == PoolW'(NumPools - 1)) build_q <= 1'b0;
        bld_p_q <= bld_p_q + PoolW'(1);
      end

      unique case (state_q)
        BkIdle: begin
          if (item_pop_o) begin
            it_q      <= item_i;
            pool_q    <= ((item_i.cmd == CmdFree) && item_i.owned) ? item_i.pool : '0;
            idx_q     <= '0;
            rem_q     <= item_i.offset;
            step_q    <= StepW'(IdxW - 1);
            granted_q <= '0;
            status_q  <= (item_i.cmd == CmdAlloc) ? StAllocFail : StNotOwned;
          end
        end
        BkPick: begin
          if (pick_ok) begin
            fc_q[pick_p] <= fc_q[pick_p] - CountW'(1);
            if ({1'b0, pick_pos} < low_q[pick_p]) low_q[pick_p] <= {1'b0, pick_pos};
            pool_q <= pick_p;
            pos_q  <= pick_pos;
            init_q <= ({1'b0, pick_pos} < low_q[pick_p]);
          end
        end
        BkMul: begin
          idx_q  <= sel_idx;
          prod_q <= OffW'(sel_idx * cur_size);
        end
        BkAdd: granted_q <= tbl_q.base[pool_q] + AddrW'(prod_q);
        BkMark: begin
          row_vld_q[row_addr] <= 1'b1;
          status_q            <= StOk;
        end
        BkDiv: begin
          if (rem_q >= trial) begin
            rem_q         <= rem_q - trial;
            idx_q[step_q] <= 1'b1;
          end
          step_q <= step_q - StepW'(1);
        end
        BkRowRd: ;
        BkCheck: begin
          if (free_ok) begin
            row_vld_q[row_addr] <= 1'b1;
            fc_q[pool_q]        <= fc_q[pool_q] + CountW'(1);
            status_q            <= StOk;
          end else begin
            status_q <= StDoubleFree;
          end
        end
        BkDone: ;
        default: ;
      endcase
    end
  end

  // free stack memory
  always_ff @(posedge clk_i) begin
    if ((state_q == BkCheck) && free_ok) stack_mem[stack_waddr] <= idx_q;
    stack_rd_q <= stack_mem[stack_raddr];
  end

  // bitmap memory, read-modify-write by row
  always_ff @(posedge clk_i) begin
    if (state_q == BkMark) begin
      bm_mem[row_addr] <= row_cur | (RowW'(1) << idx_q[RowSelW-1:0]);
    end else if ((state_q == BkCheck) && free_ok) begin
      bm_mem[row_addr] <= row_cur & ~(RowW'(1) << idx_q[RowSelW-1:0]);
    end
    row_rd_q <= bm_mem[row_addr];
    row_vs_q <= row_vld_q[row_addr];
  end

  // result queue
  assign rq_full = (rq_cnt_q == 2'd2);
  assign empty   = (rq_cnt_q == 2'd0);
  assign res_o   = rq_mem_q[rq_rd_q];

  always_ff @(posedge clk_i) begin
    if (enq) rq_mem_q[rq_wr_q] <= '{status: status_q, granted: granted_q,
                                     pool: pool_q, all_free: all_free};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_q  <= 1'b0;
      rq_rd_q  <= 1'b0;
      rq_cnt_q <= 2'd0;
    end else begin
      if (enq) rq_wr_q <= ~rq_wr_q;
      if (pop && !empty) rq_rd_q <= ~rq_rd_q;
      rq_cnt_q <= rq_cnt_q + {1'b0, enq} - {1'b0, pop && !empty};
    end
  end

  assign tbl_o      = tbl_q;
  assign building_o = build_q;

endmodule

### design/size_class_block_pool_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_block_pool_allocator_core
// Four-pool fixed-size block allocator with LIFO free stacks per pool.
// ----------------------------------------------------------------------------
// Allocate: pick, multiply, add, mark, done (pick to done when it fails); free:
// index divider, row read, check, done (straight to done when not owned). One
// item at a time in the back, so no new item is taken until the last is queued;
// a free is paced by the one-bit-per-cycle index divider and the bitmap row update.
// Reset and every config write rebuild the pool table one pool at a time, with full
// held high; the bitmap is cleared at once by per-row valid bits.
module size_class_block_pool_allocator_core import scbpa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                push,
  output logic                full,
  input  logic                cmd_i,
  input  logic [ReqW-1:0]     request_size_i,
  input  logic [AddrW-1:0]    block_address_i,
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          status_o,
  output logic [AddrW-1:0]    granted_address_o,
  output logic [PoolW-1:0]    pool_used_o,
  output logic                all_free_o
);

  pool_tbl_t tbl;
  item_t     fr_item, q_item;
  logic      q_full, q_empty, q_pop, building;
  result_t   res;

  scbpa_front u_front (
    .cmd_i           (cmd_i),
    .request_size_i  (request_size_i),
    .block_address_i (block_address_i),
    .tbl_i           (tbl),
    .item_o          (fr_item)
  );

  scbpa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && !full),
    .item_i  (fr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (q_item)
  );

  scbpa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .tbl_o        (tbl),
    .building_o   (building),
    .item_valid_i (!q_empty),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .res_o        (res),
    .empty        (empty),
    .pop          (pop)
  );

  // hold off requests while the pool table is rebuilt
  assign full              = q_full || building;
  assign status_o          = res.status;
  assign granted_address_o = res.granted;
  assign pool_used_o       = res.pool;
  assign all_free_o        = res.all_free;

endmodule

### design/scbpa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbpa_checker
// Port-level checks on the allocator results and on config blocking, bound to the top level.
// ----------------------------------------------------------------------------
`include "size_class_block_pool_allocator_core_macros.svh"

module scbpa_checker import scbpa_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_we_i,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input logic [1:0]          status_o,
  input logic [AddrW-1:0]    granted_address_o,
  input logic [PoolW-1:0]    pool_used_o,
  input logic                all_free_o
);

  `SCBPA_ASSERT_IMPLY(a_fail_no_addr, clk_i, rst_ni, !empty && (status_o == StAllocFail), granted_address_o == '0 && pool_used_o == '0)
  `SCBPA_ASSERT_IMPLY(a_unowned_pool0, clk_i, rst_ni, !empty && (status_o == StNotOwned), pool_used_o == '0 && granted_address_o == '0)
  `SCBPA_ASSERT_IMPLY(a_dbl_no_addr, clk_i, rst_ni, !empty && (status_o == StDoubleFree), granted_address_o == '0)
  `SCBPA_ASSERT_NEXT(a_hold_result, clk_i, rst_ni, !empty && !pop, !empty && $stable(status_o) && $stable(granted_address_o) && $stable(all_free_o))
  `SCBPA_ASSERT_NEXT(a_cfg_blocks, clk_i, rst_ni, cfg_we_i, full)

endmodule

bind size_class_block_pool_allocator_core scbpa_checker u_scbpa_checker (.*);

### test/tb_size_class_block_pool_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_size_class_block_pool_allocator_core
// Self-checking bench for the block pool allocator: layouts are set over the
// config port, allocate/free requests are sent through the push/full queue,
// and each popped result is checked with an in-bench pool model or typed row.
// ----------------------------------------------------------------------------
module tb_size_class_block_pool_allocator_core;
  import scbpa_pkg::*;

  typedef struct {
    status_e          status;
    logic [AddrW-1:0] granted;
    logic [PoolW-1:0] pool;
    logic             all_free;
  } alloc_result_t;

  typedef struct {
    cmd_e    cmd;
    int      req;
    int      addr;
    bit      typed;
    status_e status;
    int      granted;
    int      pool;
    bit      all_free;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                push = 1'b0;
  logic                full;
  logic                cmd_i = 1'b0;
  logic [ReqW-1:0]     request_size_i = '0;
  logic [AddrW-1:0]    block_address_i = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [1:0]          status_o;
  logic [AddrW-1:0]    granted_address_o;
  logic [PoolW-1:0]    pool_used_o;
  logic                all_free_o;

  size_class_block_pool_allocator_core u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .push, .full, .cmd_i, .request_size_i, .block_address_i,
    .empty, .pop, .status_o, .granted_address_o, .pool_used_o, .all_free_o
  );

  // pool model
  int unsigned reg_size[NumPools];
  int unsigned reg_count[NumPools];
  int unsigned blk_size[NumPools];
  int unsigned blk_count[NumPools];
  int unsigned base_addr[NumPools];
  int unsigned free_left[NumPools];
  int unsigned lifo[NumPools][MaxBlocks];
  bit          in_use[NumPools][MaxBlocks];
  int unsigned live_pools;
  int unsigned layout_bytes;
  int unsigned granted_q[$];

  alloc_result_t pending_q[$];
  int            errors = 0;
  int            send_idle_pct = 0;
  int            pop_stall_pct = 0;
  int            hold_off_cycles = 0;
  bit            hold_off_req = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void rebuild_pools();
    int unsigned off, sz, cnt, region;
    bit ended;
    off = 0;
    ended = 1'b0;
    live_pools = 0;
    for (int p = 0; p < NumPools; p++) begin
      sz = reg_size[p];
      cnt = reg_count[p];
      if (sz < MinSize) sz = MinSize;
      if (sz > MaxSize) sz = MaxSize;
      if (cnt > MaxBlocks) cnt = MaxBlocks;
      if (cnt == 0) ended = 1'b1;
      if (ended) cnt = 0;
      blk_size[p] = sz;
      blk_count[p] = cnt;
      base_addr[p] = off;
      free_left[p] = cnt;
      for (int i = 0; i < MaxBlocks; i++) begin
        in_use[p][i] = 1'b0;
        lifo[p][i] = (i < cnt) ? i : 0;
      end
      if (!ended) begin
        region = cnt * sz + (cnt + 7) / 8;
        region = (region + 15) & ~32'd15;
        off += region;
        live_pools = p + 1;
      end
    end
    layout_bytes = off;
    granted_q.delete();
  endfunction

  function automatic alloc_result_t predict_alloc_free(cmd_e cmd, int unsigned req,
                                                       int unsigned addr);
    alloc_result_t r;
    int unsigned idx, b;
    bit done;
    r.granted = '0;
    r.pool = '0;
    done = 1'b0;
    if (cmd == CmdAlloc) begin
      r.status = StAllocFail;
      if (live_pools > 0 && req <= blk_size[live_pools-1]) begin
        for (int p = 0; p < live_pools; p++) begin
          if (!done && req <= blk_size[p] && free_left[p] > 0) begin
            free_left[p]--;
            idx = lifo[p][free_left[p]];
            in_use[p][idx] = 1'b1;
            r.granted = AddrW'(base_addr[p] + idx * blk_size[p]);
            r.pool = PoolW'(p);
            r.status = StOk;
            granted_q.push_back(base_addr[p] + idx * blk_size[p]);
            done = 1'b1;
          end
        end
      end
    end else begin
      r.status = StNotOwned;
      if (addr < layout_bytes) begin
        for (int p = 0; p < live_pools; p++) begin
          b = base_addr[p];
          if (!done && addr >= b && addr < b + blk_count[p] * blk_size[p]) begin
            idx = (addr - b) / blk_size[p];
            r.pool = PoolW'(p);
            if (in_use[p][idx] && free_left[p] < MaxBlocks) begin
              in_use[p][idx] = 1'b0;
              lifo[p][free_left[p]] = idx;
              free_left[p]++;
              r.status = StOk;
            end else begin
              r.status = StDoubleFree;
            end
            done = 1'b1;
          end
        end
      end
    end
    r.all_free = 1'b1;
    for (int p = 0; p < live_pools; p++)
      if (free_left[p] != blk_count[p]) r.all_free = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Send one request; push stays high from the previous request unless idled.
  task automatic send_request(cmd_e cmd, int unsigned req, int unsigned addr,
                              output alloc_result_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    cmd_i <= cmd;
    request_size_i <= req[ReqW-1:0];
    block_address_i <= addr[AddrW-1:0];
    do @(posedge clk_i); while (full);
    r = predict_alloc_free(cmd, req, addr);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_pools(int unsigned sz[NumPools], int unsigned cnt[NumPools]);
    for (int i = 0; i < 2 * NumPools; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= i[CfgIdxW-1:0];
      cfg_wdata_i <= (i % 2 == CfgCountBit) ? sz[i/2][CfgDataW-1:0]
                                            : cnt[i/2][CfgDataW-1:0];
      @(posedge clk_i);
      if (i % 2 == CfgCountBit) reg_size[i/2] = sz[i/2] & 32'h7FF;
      else reg_count[i/2] = cnt[i/2] & 32'h1FF;
      rebuild_pools();
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_request();
    alloc_result_t r;
    int unsigned sel, req, addr, k, p;
    cmd_e cmd;
    sel = $urandom_range(0, 99);
    req = $urandom_range(0, 65535);
    addr = $urandom_range(0, 2097151);
    cmd = CmdAlloc;
    if (sel < 10) begin
      cmd = cmd_e'($urandom_range(0, 1));
    end else if (sel < 55) begin
      if (live_pools > 0) req = $urandom_range(0, blk_size[live_pools-1]);
    end else begin
      cmd = CmdFree;
      if (granted_q.size() > 0 && $urandom_range(0, 3) != 0) begin
        k = $urandom_range(0, granted_q.size() - 1);
        addr = granted_q[k] + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 0);
        granted_q.delete(k);
      end else if (live_pools > 0) begin
        p = $urandom_range(0, live_pools - 1);
        addr = base_addr[p] + $urandom_range(0, blk_count[p] - 1) * blk_size[p];
      end
    end
    send_request(cmd, req, addr, r);
    pending_q.push_back(r);
  endtask

  // Result side: check each popped result, then choose next cycle's pop.
  initial begin
    alloc_result_t want;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (pending_q.size() == 0) begin
          report_mismatch("unexpected result, status", status_o, -1);
        end else begin
          want = pending_q.pop_front();
          if (status_o != want.status) report_mismatch("status", status_o, want.status);
          if (granted_address_o != want.granted)
            report_mismatch("granted_address", granted_address_o, want.granted);
          if (pool_used_o != want.pool) report_mismatch("pool_used", pool_used_o, want.pool);
          if (all_free_o != want.all_free)
            report_mismatch("all_free", all_free_o, want.all_free);
        end
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_off_cycles = 400;
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= pop_stall_pct);
      end
    end
  end

  initial begin
    #5ms;
    $display("** size_class_block_pool_allocator_core: FAILED **");
    $finish;
  end

  initial begin
    dir_row_t rows[$];
    alloc_result_t r, typed_r;
    int unsigned sz[NumPools], cnt[NumPools];
    int mode;

    // reset layout: no valid pool, everything fails
    rows.push_back('{CmdAlloc, 0, 0, 1, StAllocFail, 0, 0, 1});
    rows.push_back('{CmdAlloc, 65535, 0, 1, StAllocFail, 0, 0, 1});
    rows.push_back('{CmdFree, 0, 0, 1, StNotOwned, 0, 0, 1});
    rows.push_back('{CmdFree, 0, 2097151, 1, StNotOwned, 0, 0, 1});
    // small four-pool layout: sizes 4,16,64,1024 counts 2,3,1,1
    rows.push_back('{CmdAlloc, 0, 0, 0, StOk, 0, 0, 0});
    rows.push_back('{CmdAlloc, 4, 0, 0, StOk, 0, 0, 0});
    rows.push_back('{CmdAlloc, 4, 0, 0, StOk, 0, 0, 0});
    rows.push_back('{CmdAlloc, 5, 0, 0, StOk, 0, 0, 0});
    rows.push_back('{CmdAlloc, 1024, 0, 0, StOk, 0, 0, 0});
    rows.push_back('{CmdAlloc, 1025, 0, 0, StOk, 0, 0, 0});
    rows.push_back('{CmdAlloc, 65535, 0, 0, StOk, 0, 0, 0});
    rows.push_back('{CmdAlloc, 64, 0, 0, StOk, 0, 0, 0});
    rows.push_back('{CmdAlloc, 64, 0, 0, StOk, 0, 0, 0});
    rows.push_back('{CmdFree, 0, 0, 0, StOk, 0, 0, 0});
    rows.push_back('{CmdFree, 0, 0, 0, StOk, 0, 0, 0});
    rows.push_back('{CmdFree, 0, 7, 0, StOk, 0, 0, 0});
    rows.push_back('{CmdFree, 0, 8, 0, StOk, 0, 0, 0});
    rows.push_back('{CmdFree, 0, 36, 0, StOk, 0, 0, 0});
    rows.push_back('{CmdFree, 0, 80, 0, StOk, 0, 0, 0});
    rows.push_back('{CmdFree, 0, 2097151, 0, StOk, 0, 0, 0});
    rows.push_back('{CmdAlloc, 0, 0, 0, StOk, 0, 0, 0});

    for (int p = 0; p < NumPools; p++) begin
      reg_size[p] = SizeReset[p];
      reg_count[p] = 0;
    end
    rebuild_pools();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      if (i == 4) begin
        wait_drained();
        sz = '{4, 16, 64, 1024};
        cnt = '{2, 3, 1, 1};
        write_pools(sz, cnt);
      end
      send_request(rows[i].cmd, rows[i].req, rows[i].addr, r);
      if (rows[i].typed) begin
        typed_r.status = rows[i].status;
        typed_r.granted = AddrW'(rows[i].granted);
        typed_r.pool = PoolW'(rows[i].pool);
        typed_r.all_free = rows[i].all_free;
        r = typed_r;
      end
      pending_q.push_back(r);
    end

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      case (ph)
        0: begin sz = '{16, 32, 64, 128};     cnt = '{8, 8, 8, 8};       end
        1: begin sz = '{1024, 1024, 1024, 1024}; cnt = '{256, 256, 256, 256}; end
        2: begin sz = '{0, 3, 2047, 1024};    cnt = '{5, 511, 7, 3};     end
        3: begin sz = '{64, 32, 8, 100};      cnt = '{4, 4, 0, 9};       end
        4: begin sz = '{4, 4, 4, 4};          cnt = '{1, 1, 1, 1};       end
        5: begin sz = '{1, 2, 4, 8};          cnt = '{0, 3, 3, 3};       end
        default: begin
          for (int p = 0; p < NumPools; p++) begin
            sz[p] = $urandom_range(0, 2047);
            cnt[p] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                 : $urandom_range(1, 12);
          end
        end
      endcase
      write_pools(sz, cnt);
      mode = ph % 4;
      send_idle_pct = (mode == 1 || mode == 3) ? ((mode == 1) ? 69 : 10) : 0;
      pop_stall_pct = (mode == 2) ? 69 : ((mode == 3) ? 10 : 0);
      // stall the result side long enough to back up the input queue
      if (ph == 0) hold_off_req = 1'b1;
      for (int n = 0; n < 185; n++) random_request();
    end

    wait_drained();
    if (errors == 0) begin
      $display("** size_class_block_pool_allocator_core: PASSED **");
    end else begin
      $display("** size_class_block_pool_allocator_core: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/scbpa_pkg.sv
design/scbpa_front.sv
design/scbpa_queue.sv
design/scbpa_back.sv
design/size_class_block_pool_allocator_core.sv
design/scbpa_checker.sv
test/tb_size_class_block_pool_allocator_core.sv
